/* hdl/nrsc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the SNTP reply sample pipeline.
// No dependencies; imported by every nrsc module.
package nrsc_pkg;

    localparam int NUM_W  = 73;   // quotient / numerator width of the divider chain
    localparam int REM_W  = 32;   // remainder width (remainder < divisor)
    localparam int MS_W   = 43;   // signed Unix-ms width of a server timestamp
    localparam int STAMP_W = 63;  // local counter stamp width
    localparam int RTT_W  = 31;

    localparam logic signed [32:0] NTP_UNIX_EPOCH_S = 33'sd2208988800;
    localparam logic [9:0]  MS_PER_S        = 10'd1000;
    localparam logic [10:0] MIN_REPLY_BYTES = 11'd48;
    localparam logic [7:0]  STRATUM_LIMIT   = 8'd16;
    localparam logic [1:0]  LEAP_ALARM      = 2'd3;
    localparam logic [2:0]  VERSION_3       = 3'd3;
    localparam logic [2:0]  VERSION_4       = 3'd4;
    localparam logic [2:0]  MODE_SERVER     = 3'd4;
    localparam logic [31:0] FREQ_RESET      = 32'd10000000;
    localparam logic [RTT_W-1:0] RTT_MAX    = 31'h7fffffff;

    typedef enum logic [2:0] {
        RSN_OK        = 3'd0,
        RSN_SHORT     = 3'd1,
        RSN_ALARM     = 3'd2,
        RSN_VERSION   = 3'd3,
        RSN_MODE      = 3'd4,
        RSN_STRATUM   = 3'd5,
        RSN_ZERO_TIME = 3'd6
    } reason_t;

    // Side data that rides along the divider chain with each request.
    typedef struct packed {
        logic                     vld;
        reason_t                  reason;
        logic signed [MS_W-1:0]   tx_ms;
        logic [MS_W-1:0]          proc_ms;
        logic [STAMP_W-1:0]       stamp;
    } cell_data_t;

endpackage

/* hdl/nrsc_front.sv */
`timescale 1ns / 1ps
// Front end: reply checks, counter delta, NTP-to-Unix-ms conversion and
// divider numerator, in three register stages. Depends on nrsc_pkg.
module nrsc_front
    import nrsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [31:0]          divisor,
    input  logic [10:0]          reply_length,
    input  logic [7:0]           header_byte,
    input  logic [7:0]           stratum,
    input  logic [31:0]          rx_seconds,
    input  logic [31:0]          rx_fraction,
    input  logic [31:0]          tx_seconds,
    input  logic [31:0]          tx_fraction,
    input  logic [STAMP_W-1:0]   send_stamp,
    input  logic [STAMP_W-1:0]   receive_stamp_in,
    output cell_data_t           data_out,
    output logic [NUM_W-1:0]     num_out
);

    localparam logic signed [MS_W-1:0] MS_PER_S_S = MS_W'(MS_PER_S);

    function automatic logic [9:0] frac_to_ms(input logic [31:0] frac);
        logic [41:0] prod;
        prod = 42'(frac) * 42'(MS_PER_S);
        return prod[41:32];
    endfunction

    // stage A
    logic                       a_vld_reg;
    reason_t                    a_reason_reg, a_reason_next;
    logic [STAMP_W-1:0]         a_dt_reg, a_dt_next;
    logic signed [32:0]         a_rx_off_reg, a_tx_off_reg;
    logic [31:0]                a_rx_frac_reg, a_tx_frac_reg;
    logic [STAMP_W-1:0]         a_stamp_reg;
    logic [STAMP_W:0]           a_diff;

    // stage B
    logic                       b_vld_reg;
    reason_t                    b_reason_reg;
    logic signed [MS_W-1:0]     b_rx_ms_reg, b_rx_ms_next;
    logic signed [MS_W-1:0]     b_tx_ms_reg, b_tx_ms_next;
    logic [NUM_W-1:0]           b_num_reg, b_num_next;
    logic [STAMP_W-1:0]         b_stamp_reg;

    // stage C
    logic                       c_vld_reg;
    cell_data_t                 c_data_reg, c_data_next;
    logic [NUM_W-1:0]           c_num_reg;

    always_comb
    begin
        if (reply_length < MIN_REPLY_BYTES)
            a_reason_next = RSN_SHORT;
        else if (header_byte[7:6] == LEAP_ALARM)
            a_reason_next = RSN_ALARM;
        else if (header_byte[5:3] != VERSION_3 && header_byte[5:3] != VERSION_4)
            a_reason_next = RSN_VERSION;
        else if (header_byte[2:0] != MODE_SERVER)
            a_reason_next = RSN_MODE;
        else if (stratum == 8'd0 || stratum >= STRATUM_LIMIT)
            a_reason_next = RSN_STRATUM;
        else if (rx_seconds == 32'd0 || tx_seconds == 32'd0)
            a_reason_next = RSN_ZERO_TIME;
        else
            a_reason_next = RSN_OK;

        // clamp arrival-before-send to zero
        a_diff    = {1'b0, receive_stamp_in} - {1'b0, send_stamp};
        a_dt_next = a_diff[STAMP_W] ? '0 : a_diff[STAMP_W-1:0];
    end

    always_comb
    begin
        b_rx_ms_next = MS_W'(a_rx_off_reg) * MS_PER_S_S
                     + $signed(MS_W'(frac_to_ms(a_rx_frac_reg)));
        b_tx_ms_next = MS_W'(a_tx_off_reg) * MS_PER_S_S
                     + $signed(MS_W'(frac_to_ms(a_tx_frac_reg)));
        // round half up: add half the divisor before dividing
        b_num_next   = NUM_W'(a_dt_reg) * NUM_W'(MS_PER_S) + NUM_W'(divisor[31:1]);
    end

    always_comb
    begin
        c_data_next.vld     = b_vld_reg;
        c_data_next.reason  = b_reason_reg;
        c_data_next.tx_ms   = b_tx_ms_reg;
        c_data_next.proc_ms = (b_tx_ms_reg > b_rx_ms_reg)
                            ? MS_W'(b_tx_ms_reg - b_rx_ms_reg) : '0;
        c_data_next.stamp   = b_stamp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= accept;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= c_data_next.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reason_reg  <= a_reason_next;
        a_dt_reg      <= a_dt_next;
        a_rx_off_reg  <= $signed({1'b0, rx_seconds}) - NTP_UNIX_EPOCH_S;
        a_tx_off_reg  <= $signed({1'b0, tx_seconds}) - NTP_UNIX_EPOCH_S;
        a_rx_frac_reg <= rx_fraction;
        a_tx_frac_reg <= tx_fraction;
        a_stamp_reg   <= receive_stamp_in;

        b_reason_reg  <= a_reason_reg;
        b_rx_ms_reg   <= b_rx_ms_next;
        b_tx_ms_reg   <= b_tx_ms_next;
        b_num_reg     <= b_num_next;
        b_stamp_reg   <= a_stamp_reg;

        c_data_reg    <= c_data_next;
        c_num_reg     <= b_num_reg;
    end

    always_comb
    begin
        data_out     = c_data_reg;
        data_out.vld = c_vld_reg;
    end

    assign num_out  = c_num_reg;

endmodule

/* hdl/nrsc_div_cell.sv */
`timescale 1ns / 1ps
// One restoring-division cell: yields one quotient bit per request and hands
// remainder, shifted numerator and side data to the next cell. Depends on nrsc_pkg.
module nrsc_div_cell
    import nrsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [REM_W-1:0]  divisor,
    input  cell_data_t        data_in,
    input  logic [REM_W-1:0]  rem_in,
    input  logic [NUM_W-1:0]  num_in,
    output cell_data_t        data_out,
    output logic [REM_W-1:0]  rem_out,
    output logic [NUM_W-1:0]  num_out
);

    logic               vld_reg;
    cell_data_t         data_reg;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [REM_W:0]     trial;
    logic [REM_W:0]     sub;
    logic               q_bit;

    always_comb
    begin
        // bring down the next numerator bit, try the subtract
        trial    = {rem_in, num_in[NUM_W-1]};
        sub      = trial - {1'b0, divisor};
        q_bit    = (trial >= {1'b0, divisor});
        rem_next = q_bit ? sub[REM_W-1:0] : trial[REM_W-1:0];
        num_next = {num_in[NUM_W-2:0], q_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= data_in.vld;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_in;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
    end

    always_comb
    begin
        data_out     = data_reg;
        data_out.vld = vld_reg;
    end

    assign rem_out  = rem_reg;
    assign num_out  = num_reg;

endmodule

/* hdl/nrsc_back.sv */
`timescale 1ns / 1ps
// Back end: saturates the round trip, removes server processing time, halves
// it and adds it to the transmit time; drives the result registers. Depends on nrsc_pkg.
module nrsc_back
    import nrsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_data_t           data_in,
    input  logic [NUM_W-1:0]     quot_in,
    output logic                 done,
    output logic                 sample_valid,
    output logic [2:0]           reject_reason,
    output logic signed [63:0]   utc_ms,
    output logic [STAMP_W-1:0]   receive_stamp,
    output logic [RTT_W-1:0]     rtt_ms
);

    // stage E1
    logic                e_vld_reg;
    cell_data_t          e_data_reg;
    logic [RTT_W-1:0]    e_rtt_reg, e_rtt_next;
    logic [63:0]         e_half_reg, e_half_next;
    logic [NUM_W:0]      e_diff;

    // stage E2 (output)
    logic                done_reg;
    logic                ok_reg, ok_next;
    reason_t             reason_reg;
    logic [63:0]         utc_reg, utc_next;
    logic [STAMP_W-1:0]  stamp_reg, stamp_next;
    logic [RTT_W-1:0]    rtt_reg, rtt_next;

    always_comb
    begin
        e_rtt_next  = (|quot_in[NUM_W-1:RTT_W]) ? RTT_MAX : quot_in[RTT_W-1:0];
        // clamp at zero when processing time covers the whole round trip
        e_diff      = {1'b0, quot_in} - (NUM_W+1)'(data_in.proc_ms);
        e_half_next = e_diff[NUM_W] ? '0 : e_diff[64:1];
    end

    always_comb
    begin
        ok_next    = (e_data_reg.reason == RSN_OK);
        utc_next   = ok_next ? (64'(e_data_reg.tx_ms) + e_half_reg) : '0;
        stamp_next = ok_next ? e_data_reg.stamp : '0;
        rtt_next   = ok_next ? e_rtt_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            e_vld_reg <= data_in.vld;
            done_reg  <= e_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_data_reg <= data_in;
        e_rtt_reg  <= e_rtt_next;
        e_half_reg <= e_half_next;

        ok_reg     <= ok_next;
        reason_reg <= e_data_reg.reason;
        utc_reg    <= utc_next;
        stamp_reg  <= stamp_next;
        rtt_reg    <= rtt_next;
    end

    assign done          = done_reg;
    assign sample_valid  = ok_reg;
    assign reject_reason = reason_reg;
    assign utc_ms        = $signed(utc_reg);
    assign receive_stamp = stamp_reg;
    assign rtt_ms        = rtt_reg;

endmodule

/* hdl/ntp_reply_sample_compute.sv */
`timescale 1ns / 1ps
// Top level of the SNTP reply sample pipeline: counter frequency register,
// front end, divider cell chain and back end. Depends on nrsc_pkg and all nrsc modules.
//
// Usage
//   Request channel: drive the decoded reply fields and the two local counter
//   stamps with start high; the request is taken at a rising edge where start
//   is high and busy is low. busy is high during reset and until the first
//   rising edge after it; after that a new request may be issued in every cycle.
//   Result channel: done pulses for one cycle with sample_valid, reject_reason,
//   utc_ms, receive_stamp and rtt_ms. The receiver cannot stall; each result is
//   shown for exactly that one cycle. Rejected replies give zero time fields.
//   Pipeline: the accepting edge loads the first of 78 register stages (three
//   front stages, one cell per quotient bit of the 73-bit round trip quotient,
//   two back stages); done rises as the last stage loads. Throughput: one
//   request per cycle, results in request order.
//   Configuration: cfg_we/cfg_data write the counter frequency (ticks per
//   second, zero acts as one). Write only with no request in flight.
//   Reset: asynchronous, clears all valid bits and loads the frequency with
//   10 MHz; requests in flight are dropped.
module ntp_reply_sample_compute
    import nrsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [10:0]          reply_length,
    input  logic [7:0]           header_byte,
    input  logic [7:0]           stratum,
    input  logic [31:0]          rx_seconds,
    input  logic [31:0]          rx_fraction,
    input  logic [31:0]          tx_seconds,
    input  logic [31:0]          tx_fraction,
    input  logic [62:0]          send_stamp,
    input  logic [62:0]          receive_stamp_in,
    output logic                 done,
    output logic                 sample_valid,
    output logic [2:0]           reject_reason,
    output logic signed [63:0]   utc_ms,
    output logic [62:0]          receive_stamp,
    output logic [30:0]          rtt_ms,
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_data
);

    logic              busy_reg;
    logic [31:0]       freq_reg, freq_next;
    logic              accept;

    // divider chain taps: index 0 feeds the first cell
    cell_data_t        chain_data [0:NUM_W];
    logic [REM_W-1:0]  chain_rem  [0:NUM_W];
    logic [NUM_W-1:0]  chain_num  [0:NUM_W];

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // store a zero frequency as one so the divider never sees zero
    assign freq_next = (cfg_data == 32'd0) ? 32'd1 : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            freq_reg <= FREQ_RESET;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_we)
                freq_reg <= freq_next;
        end
    end

    nrsc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .divisor          (freq_reg),
        .reply_length     (reply_length),
        .header_byte      (header_byte),
        .stratum          (stratum),
        .rx_seconds       (rx_seconds),
        .rx_fraction      (rx_fraction),
        .tx_seconds       (tx_seconds),
        .tx_fraction      (tx_fraction),
        .send_stamp       (send_stamp),
        .receive_stamp_in (receive_stamp_in),
        .data_out         (chain_data[0]),
        .num_out          (chain_num[0])
    );

    // start every request with an empty remainder
    assign chain_rem[0] = '0;

    // advance one quotient bit per cell, MSB first
    for (genvar i = 0; i < NUM_W; i++)
    begin : g_cell
        nrsc_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .divisor  (freq_reg),
            .data_in  (chain_data[i]),
            .rem_in   (chain_rem[i]),
            .num_in   (chain_num[i]),
            .data_out (chain_data[i+1]),
            .rem_out  (chain_rem[i+1]),
            .num_out  (chain_num[i+1])
        );
    end

    nrsc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_in       (chain_data[NUM_W]),
        .quot_in       (chain_num[NUM_W]),
        .done          (done),
        .sample_valid  (sample_valid),
        .reject_reason (reject_reason),
        .utc_ms        (utc_ms),
        .receive_stamp (receive_stamp),
        .rtt_ms        (rtt_ms)
    );

    // the stored frequency is never zero
    a_freq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        freq_reg != 32'd0)
        else $error("counter frequency register holds zero");

    // the final remainder of a division stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chain_data[NUM_W].vld |-> (chain_rem[NUM_W] < freq_reg))
        else $error("divider remainder out of range");

    // a rejected reply carries zero time fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !sample_valid) |->
            (utc_ms == 64'sd0 && rtt_ms == 31'd0 && receive_stamp == 63'd0
             && reject_reason != RSN_OK))
        else $error("rejected result with nonzero payload");

endmodule
